### rtl/lfu_write_back_block_cache_defines.svh
// Assertion macros used by the checker file.
`ifndef LFU_WRITE_BACK_BLOCK_CACHE_DEFINES_SVH
`define LFU_WRITE_BACK_BLOCK_CACHE_DEFINES_SVH
// Assert that an implication holds at every clock edge outside reset.
`define LFU_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Assert that an implication holds in the next cycle.
`define LFU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

### rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Types, codes and defaults shared by the block cache modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lfu_pkg;
    localparam int unsigned DEF_ENTRIES     = 128;
    localparam int unsigned DEF_BLOCK_BYTES = 8;
    localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_FILL   = 2'd1,
        CMD_WRITE  = 2'd2,
        CMD_FLUSH  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_HIT           = 3'd0,
        ST_MISS          = 3'd1,
        ST_LEN_MISMATCH  = 3'd2,
        ST_STORED        = 3'd3,
        ST_NOT_STORED    = 3'd4,
        ST_FLUSHED       = 3'd5,
        ST_NOTHING_DIRTY = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_ACT,
        S_DONE
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture input item, clear scan results
        logic scan_rd;   // issue a memory read at scan index
        logic act;       // apply the command using scan results
    } cmd_bus_t;

    // Datapath to controller.
    typedef struct packed {
        logic scan_last; // read issued for the last entry
    } stat_bus_t;
endpackage
`default_nettype wire

### rtl/lfu_write_back_block_cache.sv
// ----------------------------------------------------------------------------
// lfu_write_back_block_cache
// Fully associative write-back block cache with least-frequently-used eviction.
// ----------------------------------------------------------------------------
// Channel  Prefix  Handshake      Fields
// input    s_      valid/ready    command, block_addr, block_len, block_data
// result   m_      valid/ready    status, read_data, flush_addr, flush_len
//
// Each command scans every entry with one memory read per entry, then passes
// through a wait state for the last read to settle and an action state before
// the result is valid.
// One command is in flight at a time; s_ready is low until the result transfers.
// Reset is synchronous and active low; it clears all valid and dirty marks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lfu_write_back_block_cache
    import lfu_pkg::*;
#(
    parameter int unsigned ENTRIES     = DEF_ENTRIES,
    parameter int unsigned BLOCK_BYTES = DEF_BLOCK_BYTES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [15:0] s_block_addr,
    input  wire logic [3:0]  s_block_len,
    input  wire logic [63:0] s_block_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [63:0]      m_read_data,
    output logic [15:0]      m_flush_addr,
    output logic [3:0]       m_flush_len
);
    cmd_bus_t  cmd;
    stat_bus_t stat;

    // The sequencer steps the datapath through one full scan per command.
    lfu_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .cmd(cmd), .stat(stat)
    );

    // The datapath holds entries and registers the result until transfer.
    lfu_datapath #(.ENTRIES(ENTRIES), .BLOCK_BYTES(BLOCK_BYTES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .in_command(s_command), .in_addr(s_block_addr),
        .in_len(s_block_len), .in_data(s_block_data),
        .out_status(m_status), .out_read_data(m_read_data),
        .out_flush_addr(m_flush_addr), .out_flush_len(m_flush_len)
    );
endmodule
`default_nettype wire

### rtl/lfu_datapath.sv
// ----------------------------------------------------------------------------
// lfu_datapath
// Entry storage, the scan over all entries and the command action.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lfu_datapath
    import lfu_pkg::*;
#(
    parameter int unsigned ENTRIES     = DEF_ENTRIES,
    parameter int unsigned BLOCK_BYTES = DEF_BLOCK_BYTES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cmd_bus_t    cmd,
    output stat_bus_t        stat,
    input  wire logic [1:0]  in_command,
    input  wire logic [15:0] in_addr,
    input  wire logic [3:0]  in_len,
    input  wire logic [63:0] in_data,
    output logic [2:0]       out_status,
    output logic [63:0]      out_read_data,
    output logic [15:0]      out_flush_addr,
    output logic [3:0]       out_flush_len
);
    localparam int IW = $clog2(ENTRIES);
    localparam int DW = 8 * BLOCK_BYTES;

    // Payload memory: tag, length, counter, data. Read one address a cycle.
    logic [15:0]   tag_mem [ENTRIES];
    logic [3:0]    len_mem [ENTRIES];
    logic [15:0]   cnt_mem [ENTRIES];
    logic [DW-1:0] dat_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg, dirty_reg;

    logic [1:0]  cmd_reg;
    logic [15:0] addr_reg;
    logic [3:0]  len_reg;
    logic [63:0] data_reg;

    logic [IW-1:0] scan_reg, rd_idx_reg;
    logic          rd_vld_reg;
    logic [15:0]   rd_tag_reg, rd_cnt_reg;
    logic [3:0]    rd_len_reg;
    logic [DW-1:0] rd_dat_reg;

    logic          hit_f_reg, free_f_reg, vic_f_reg, dty_f_reg;
    logic [IW-1:0] hit_i_reg, free_i_reg, vic_i_reg, dty_i_reg;
    logic [15:0]   hit_cnt_reg, vic_cnt_reg, dty_tag_reg;
    logic [3:0]    hit_len_reg, dty_len_reg;
    logic [DW-1:0] hit_dat_reg, dty_dat_reg;

    logic [2:0]  st_reg;
    logic [63:0] rdat_reg;
    logic [15:0] fa_reg;
    logic [3:0]  fl_reg;

    logic          len_ok;
    logic [63:0]   mask;
    logic          do_store;
    logic [IW-1:0] slot;

    assign stat.scan_last = (scan_reg == IW'(ENTRIES - 1));

    always_comb begin
        len_ok = (len_reg != 4'd0) && ({28'd0, len_reg} <= 32'(BLOCK_BYTES));
        mask = (len_reg >= 4'd8) ? '1 : ((64'd1 << {len_reg[2:0], 3'b000}) - 64'd1);
        do_store = 1'b0;
        slot = hit_i_reg;
        if ((cmd_reg == CMD_FILL || cmd_reg == CMD_WRITE) && len_ok) begin
            priority if (hit_f_reg) begin
                do_store = 1'b1;
                slot = hit_i_reg;
            end else if (free_f_reg) begin
                do_store = 1'b1;
                slot = free_i_reg;
            end else if (vic_f_reg) begin
                do_store = 1'b1;
                slot = vic_i_reg;
            end
        end
    end

    // Memory read and write ports.
    always_ff @(posedge aclk) begin
        if (cmd.scan_rd) begin
            rd_tag_reg <= tag_mem[scan_reg];
            rd_len_reg <= len_mem[scan_reg];
            rd_cnt_reg <= cnt_mem[scan_reg];
            rd_dat_reg <= dat_mem[scan_reg];
        end
        if (cmd.act && do_store) begin
            tag_mem[slot] <= addr_reg;
            len_mem[slot] <= len_reg;
            cnt_mem[slot] <= '0;
            dat_mem[slot] <= DW'(data_reg & mask);
        end else if (cmd.act && cmd_reg == CMD_LOOKUP && hit_f_reg
                     && hit_cnt_reg != COUNT_MAX) begin
            cnt_mem[hit_i_reg] <= hit_cnt_reg + 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            dirty_reg <= '0;
            rd_vld_reg <= 1'b0;
            scan_reg <= '0;
        end else begin
            rd_vld_reg <= cmd.scan_rd;
            rd_idx_reg <= scan_reg;
            if (cmd.load) scan_reg <= '0;
            else if (cmd.scan_rd && !stat.scan_last) scan_reg <= scan_reg + 1'b1;
            if (cmd.act) begin
                if (do_store) begin
                    valid_reg[slot] <= 1'b1;
                    if (cmd_reg == CMD_WRITE) dirty_reg[slot] <= 1'b1;
                    else if (!hit_f_reg) dirty_reg[slot] <= 1'b0;
                end
                if (cmd_reg == CMD_FLUSH && dty_f_reg) dirty_reg[dty_i_reg] <= 1'b0;
            end
        end
    end

    // Scan accumulation, first match wins in index order.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_f_reg <= 1'b0; free_f_reg <= 1'b0;
            vic_f_reg <= 1'b0; dty_f_reg <= 1'b0;
        end else if (cmd.load) begin
            hit_f_reg <= 1'b0; free_f_reg <= 1'b0;
            vic_f_reg <= 1'b0; dty_f_reg <= 1'b0;
        end else if (rd_vld_reg) begin
            if (valid_reg[rd_idx_reg]) begin
                if (!hit_f_reg && rd_tag_reg == addr_reg) begin
                    hit_f_reg <= 1'b1; hit_i_reg <= rd_idx_reg;
                    hit_cnt_reg <= rd_cnt_reg; hit_len_reg <= rd_len_reg;
                    hit_dat_reg <= rd_dat_reg;
                end
                if (dirty_reg[rd_idx_reg]) begin
                    if (!dty_f_reg) begin
                        dty_f_reg <= 1'b1; dty_i_reg <= rd_idx_reg;
                        dty_tag_reg <= rd_tag_reg; dty_len_reg <= rd_len_reg;
                        dty_dat_reg <= rd_dat_reg;
                    end
                end else if (!vic_f_reg || rd_cnt_reg < vic_cnt_reg) begin
                    vic_f_reg <= 1'b1; vic_i_reg <= rd_idx_reg;
                    vic_cnt_reg <= rd_cnt_reg;
                end
            end else if (!free_f_reg) begin
                free_f_reg <= 1'b1; free_i_reg <= rd_idx_reg;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.act) begin
            rdat_reg <= '0; fa_reg <= '0; fl_reg <= '0;
            unique case (cmd_t'(cmd_reg))
                CMD_LOOKUP: begin
                    if (!hit_f_reg) st_reg <= ST_MISS;
                    else if (len_reg != hit_len_reg) st_reg <= ST_LEN_MISMATCH;
                    else begin
                        st_reg <= ST_HIT;
                        rdat_reg <= 64'(hit_dat_reg);
                    end
                end
                CMD_FILL, CMD_WRITE: st_reg <= do_store ? ST_STORED : ST_NOT_STORED;
                CMD_FLUSH: begin
                    if (dty_f_reg) begin
                        st_reg <= ST_FLUSHED;
                        rdat_reg <= 64'(dty_dat_reg);
                        fa_reg <= dty_tag_reg;
                        fl_reg <= dty_len_reg;
                    end else begin
                        st_reg <= ST_NOTHING_DIRTY;
                    end
                end
                default: st_reg <= ST_MISS;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg <= in_command; addr_reg <= in_addr;
            len_reg <= in_len; data_reg <= in_data;
        end
    end

    assign out_status     = st_reg;
    assign out_read_data  = rdat_reg;
    assign out_flush_addr = fa_reg;
    assign out_flush_len  = fl_reg;
endmodule
`default_nettype wire

### rtl/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: accept, scan all entries, act, hold the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lfu_ctrl
    import lfu_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    output cmd_bus_t       cmd,
    input  wire stat_bus_t stat
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid) state_next = S_SCAN;
            S_SCAN: if (stat.scan_last) state_next = S_WAIT;
            S_WAIT: state_next = S_ACT;
            S_ACT:  state_next = S_DONE;
            S_DONE: if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == S_IDLE);
        m_valid = (state_reg == S_DONE);
        cmd.load = (state_reg == S_IDLE) && s_valid;
        cmd.scan_rd = (state_reg == S_SCAN);
        cmd.act = (state_reg == S_ACT);
    end
endmodule
`default_nettype wire

### rtl/lfu_checker.sv
// ----------------------------------------------------------------------------
// lfu_checker
// Port-level checks on the block cache, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lfu_write_back_block_cache_defines.svh"
module lfu_checker
    import lfu_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_status,
    input wire logic [63:0] m_read_data,
    input wire logic [3:0]  m_flush_len
);
    `LFU_ASSERT_IMPL(a_one_at_time, aclk, aresetn, m_valid, !s_ready, "busy while result held")
    `LFU_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_valid && s_ready, !s_ready && !m_valid, "accept did not start work")
    `LFU_ASSERT_IMPL(a_status_rng, aclk, aresetn, m_valid, m_status <= ST_NOTHING_DIRTY, "bad status")
    `LFU_ASSERT_IMPL(a_flen_zero, aclk, aresetn, m_valid && m_status != ST_FLUSHED, m_flush_len == 4'd0, "flush length without flush")
    `LFU_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_read_data), "result dropped")
endmodule
bind lfu_write_back_block_cache lfu_checker u_lfu_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_read_data(m_read_data), .m_flush_len(m_flush_len)
);
`default_nettype wire
